### design/sliding_window_percent_rank_unit_defines.svh
// Assertion macros for the sliding-window percent rank unit.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef SLIDING_WINDOW_PERCENT_RANK_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_PERCENT_RANK_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/swpr_pkg.sv
// Shared constants and types for the sliding-window percent rank unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package swpr_pkg;

    localparam int MAX_PERIOD   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int PERIOD_W     = 7;
    localparam int PCT_W        = 15;
    localparam int IDX_W        = 24;
    localparam int CNT_W        = $clog2(MAX_PERIOD + 1);
    localparam int GROUP_SIZE   = 8;
    localparam int GROUP_W      = $clog2(GROUP_SIZE + 1);
    localparam int NGROUP       = (MAX_PERIOD + GROUP_SIZE - 1) / GROUP_SIZE;

    // Percent scale (100 with 8 fraction bits) and reciprocal table format.
    localparam int PCT_SCALE    = 25600;
    localparam int RECIP_SHIFT  = 17;
    localparam int RECIP_W      = 32;
    localparam int PROD_W       = CNT_W + RECIP_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;
    localparam logic [IDX_W-1:0]    IDX_MAX      = {IDX_W{1'b1}};
    localparam logic [PCT_W-1:0]    PCT_MAX      = PCT_W'(PCT_SCALE);

    // Broadcast from the top level to every cell of the window.
    typedef struct packed {
        logic                           shift_en;
        logic signed [SAMPLE_WIDTH-1:0] cur_sample;
    } swpr_cell_ctrl_t;

    // Per-item bookkeeping that travels beside the count pipeline.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] sample_index;
        logic [IDX_W-1:0] result_count;
        logic [CNT_W-1:0] period;
    } swpr_meta_t;

endpackage

`default_nettype wire

### design/swpr_cell.sv
// One window cell: holds a stored sample, passes it to the next cell on a
// shift and flags whether it is below the incoming sample. Uses swpr_pkg.
`default_nettype none

module swpr_cell (
    input  wire logic                                    clk,
    input  wire swpr_pkg::swpr_cell_ctrl_t               ctrl,
    input  wire logic                                    active,
    input  wire logic signed [swpr_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic signed [swpr_pkg::SAMPLE_WIDTH-1:0]      sample_out,
    output logic                                         lt_flag
);
    import swpr_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           lt_reg;
    logic                           lt_next;

    // Compare the stored (older) sample against the one being ranked.
    always_comb
    begin
        lt_next = active && ($signed(sample_reg) < $signed(ctrl.cur_sample));
    end

    // On a transfer, latch the compare and take the neighbor's sample.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            sample_reg <= sample_in;
            lt_reg     <= lt_next;
        end
    end

    assign sample_out = sample_reg;
    assign lt_flag    = lt_reg;

endmodule

`default_nettype wire

### design/swpr_count.sv
// Two-stage registered population count of the cell compare flags.
// Uses swpr_pkg for widths.
`default_nettype none

module swpr_count (
    input  wire logic                          clk,
    input  wire logic                          adv,
    input  wire logic [swpr_pkg::MAX_PERIOD-1:0] flags,
    output logic [swpr_pkg::CNT_W-1:0]          count
);
    import swpr_pkg::*;

    logic [NGROUP*GROUP_SIZE-1:0] flags_pad;
    logic [GROUP_W-1:0]           group_next [NGROUP];
    logic [GROUP_W-1:0]           group_reg  [NGROUP];
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             count_reg;

    assign flags_pad = (NGROUP*GROUP_SIZE)'(flags);

    // First level: count each group of eight flags.
    always_comb
    begin
        for (int g = 0; g < NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                group_next[g] = group_next[g] + GROUP_W'(flags_pad[g*GROUP_SIZE + b]);
            end
        end
    end

    // Second level: add up the group counts.
    always_comb
    begin
        count_next = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            count_next = count_next + CNT_W'(group_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                group_reg[g] <= group_next[g];
            end
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

### design/sliding_window_percent_rank_unit.sv
// Path to m_tvalid: cell compare, group count, total count, product and output registers.
// Throughput: one sample per cycle; the row of cells compares the new sample
// against every stored sample of the active window at once, and the pipeline stalls as a whole
// while a result waits on m_tready.
// Reset: counters, fill count and valid bits clear and the period returns to 14;
// the window storage is not cleared, since the fill count guards every read of it.
`default_nettype none

module sliding_window_percent_rank_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration: period register.
    input  wire logic                         period_wr_en,
    input  wire logic [swpr_pkg::PERIOD_W-1:0] period_wr_data,
    // Input stream.
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,  // [31:0] sample
    input  wire logic [1:0]                   s_tuser,  // [0] start_of_series, [1] want_result
    // Result stream.
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [14:0] percent, [38:15] sample_index, [62:39] result_count, [63] zero
    output logic [63:0]                       m_tdata
);
    import swpr_pkg::*;

    `include "sliding_window_percent_rank_unit_defines.svh"

    // Configuration register and its clamped value.
    logic [PERIOD_W-1:0] period_reg;
    logic [CNT_W-1:0]    p_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (period_wr_en)
            period_reg <= period_wr_data;
    end

    always_comb
    begin
        if (period_reg == '0)
            p_eff = CNT_W'(1);
        else if (int'(period_reg) > MAX_PERIOD)
            p_eff = CNT_W'(MAX_PERIOD);
        else
            p_eff = CNT_W'(period_reg);
    end

    // Pipeline advance: everything moves unless a result is held back.
    logic adv;
    logic accept;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    // Series bookkeeping, applied at each input transfer.
    logic [CNT_W-1:0] fill_reg, fill_base, fill_next;
    logic [IDX_W-1:0] series_reg, series_base, series_next;
    logic [IDX_W-1:0] results_given_reg, results_base, results_inc, results_next;
    logic             start, want, produce;

    assign start = s_tuser[0];
    assign want  = s_tuser[1];

    always_comb
    begin
        fill_base    = start ? '0 : fill_reg;
        series_base  = start ? '0 : series_reg;
        results_base = start ? '0 : results_given_reg;
        produce      = want && (fill_base >= p_eff);
        results_inc  = (results_base == IDX_MAX) ? results_base : results_base + IDX_W'(1);
        fill_next    = (fill_base == CNT_W'(MAX_PERIOD)) ? fill_base : fill_base + CNT_W'(1);
        series_next  = (series_base == IDX_MAX) ? series_base : series_base + IDX_W'(1);
        results_next = produce ? results_inc : results_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg          <= '0;
            series_reg        <= '0;
            results_given_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg          <= fill_next;
            series_reg        <= series_next;
            results_given_reg <= results_next;
        end
    end

    // Row of cells: cell 0 holds the newest sample.
    swpr_cell_ctrl_t                cell_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] chain [MAX_PERIOD+1];
    logic [MAX_PERIOD-1:0]          lt_flags;

    assign cell_ctrl.shift_en   = accept;
    assign cell_ctrl.cur_sample = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
    assign chain[0]             = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    for (genvar g = 0; g < MAX_PERIOD; g++)
    begin : g_cell
        logic active;

        assign active = (CNT_W'(g) < p_eff);

        swpr_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .active     (active),
            .sample_in  (chain[g]),
            .sample_out (chain[g+1]),
            .lt_flag    (lt_flags[g])
        );
    end

    // Chain tail: the oldest sample leaves the window here.
    logic signed [SAMPLE_WIDTH-1:0] tail_sample;
    assign tail_sample = chain[MAX_PERIOD];

    // Flag count, aligned with the third metadata stage.
    logic [CNT_W-1:0] rank_count;

    swpr_count u_count (
        .clk   (clk),
        .adv   (adv),
        .flags (lt_flags),
        .count (rank_count)
    );

    // Metadata stages beside the compare and count stages.
    swpr_meta_t meta_in, meta1_reg, meta2_reg, meta3_reg, meta4_reg;

    always_comb
    begin
        meta_in.valid        = accept && produce;
        meta_in.sample_index = series_base;
        meta_in.result_count = results_inc;
        meta_in.period       = p_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
            meta4_reg <= '0;
        end
        else if (adv)
        begin
            meta1_reg <= meta_in;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
        end
    end

    // Reciprocal table: ceil(25600 * 2^17 / p), exact floor for count <= p.
    logic [RECIP_W-1:0] recip_tab [MAX_PERIOD+1];

    for (genvar g = 0; g <= MAX_PERIOD; g++)
    begin : g_recip
        if (g == 0)
        begin : g_zero
            assign recip_tab[g] = '0;
        end
        else
        begin : g_entry
            localparam longint unsigned RecipVal =
                ((longint'(PCT_SCALE) << RECIP_SHIFT) + longint'(g) - 1) / longint'(g);
            assign recip_tab[g] = RECIP_W'(RecipVal);
        end
    end

    // Scale the count by the reciprocal of the period.
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            prod_reg <= PROD_W'(rank_count) * PROD_W'(recip_tab[meta3_reg.period]);
    end

    // Output register.
    logic             out_valid_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [IDX_W-1:0] out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= meta4_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pct_reg       <= prod_reg[RECIP_SHIFT +: PCT_W];
            out_index_reg <= meta4_reg.sample_index;
            out_count_reg <= meta4_reg.result_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(tail_sample[0] & 1'b0), out_count_reg, out_index_reg, pct_reg};

    // A series can never have given more results than it has samples.
    logic count_in_bounds;
    logic fill_in_bounds;

    assign count_in_bounds = ({1'b0, out_count_reg} <= ({1'b0, out_index_reg} + (IDX_W+1)'(1)));
    assign fill_in_bounds  = (fill_reg <= CNT_W'(MAX_PERIOD));

    // Checks on the block's own bookkeeping.
    `SWPR_ASSERT_SAME(a_pct_range, out_valid_reg, (pct_reg <= PCT_MAX), "percent above 100")
    `SWPR_ASSERT_SAME(a_fill_bound, 1'b1, fill_in_bounds, "fill count overrun")
    `SWPR_ASSERT_SAME(a_count_vs_index, out_valid_reg, count_in_bounds, "count exceeds index")
    `SWPR_ASSERT_NEXT(a_result_counted, (accept && produce), (results_given_reg != '0), "not counted")

endmodule

`default_nettype wire
